// ===== rtl/core/hbrv_pkg.sv =====
package hbrv_pkg;

	// Field widths
	localparam int COORD_BITS    = 24;
	localparam int OUT_FRAC_BITS = 14;
	localparam int OUT_BITS      = 16;
	localparam int THRESH_BITS   = 50;

	// Datapath widths
	localparam int DIFF_BITS = COORD_BITS + 1;      // signed coordinate difference
	localparam int MAG_BITS  = COORD_BITS;          // |difference| stays below 2^COORD_BITS
	localparam int SQ_BITS   = 2 * MAG_BITS;        // one squared component
	localparam int LEN_BITS  = SQ_BITS + 1;         // squared length
	localparam int QUO_BITS  = 2 * OUT_FRAC_BITS + 1; // a^2 * 2^(2F) / L, at most 2^(2F)
	localparam int DIV_STEPS = QUO_BITS - 1;        // top quotient bit is formed up front
	localparam int ROOT_BITS = OUT_FRAC_BITS + 1;   // square root of the quotient
	localparam int RAD_BITS  = 2 * ROOT_BITS;       // radicand, whole bit pairs
	localparam int SREM_BITS = ROOT_BITS + 2;       // square root partial remainder

	localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(1678);

	localparam logic [ROOT_BITS-1:0] ROOT_ONE = {1'b1, {OUT_FRAC_BITS{1'b0}}};
	localparam logic signed [OUT_BITS-1:0] OUT_ONE     = OUT_BITS'(ROOT_ONE);
	localparam logic signed [OUT_BITS-1:0] OUT_NEG_ONE = -OUT_ONE;

	// Input beat
	typedef struct packed {
		logic signed [COORD_BITS-1:0] sprite_x;
		logic signed [COORD_BITS-1:0] sprite_z;
		logic signed [COORD_BITS-1:0] camera_x;
		logic signed [COORD_BITS-1:0] camera_z;
	} hbrv_item_t;

	// Output beat
	typedef struct packed {
		logic signed [OUT_BITS-1:0] right_x;
		logic signed [OUT_BITS-1:0] right_z;
		logic                       degenerate;
	} hbrv_result_t;

	// Control carried alongside the data down the pipe
	typedef struct packed {
		logic valid;
		logic neg_x;   // right_x is negative
		logic neg_z;   // right_z is negative
		logic degen;   // fallback vector
	} hbrv_side_t;

	// Divider cell state, x lane divides az^2, z lane divides ax^2
	typedef struct packed {
		hbrv_side_t          side;
		logic [LEN_BITS-1:0] divisor;
		logic [LEN_BITS-1:0] rem_x;
		logic [LEN_BITS-1:0] rem_z;
		logic [QUO_BITS-1:0] quo_x;
		logic [QUO_BITS-1:0] quo_z;
	} hbrv_div_t;

	// Square root cell state
	typedef struct packed {
		hbrv_side_t           side;
		logic [RAD_BITS-1:0]  rad_x;
		logic [RAD_BITS-1:0]  rad_z;
		logic [SREM_BITS-1:0] rem_x;
		logic [SREM_BITS-1:0] rem_z;
		logic [ROOT_BITS-1:0] root_x;
		logic [ROOT_BITS-1:0] root_z;
	} hbrv_sqrt_t;

endpackage

// ===== rtl/core/horizontal_billboard_right_vector_unit.sv =====
// A beat passes the front stages and both cell rows into the output register.
// Throughput: one beat per cycle while the skid entry is empty, set by the row of 28
// divider cells and the row of 15 square root cells, each cell advancing one pipeline
// step a cycle. An output register plus one skid entry decouple the result side.
// Reset clears all valid bits and loads the threshold with 1678; no clearing pass.
module horizontal_billboard_right_vector_unit
	import hbrv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [THRESH_BITS-1:0] cfg_wdata,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  hbrv_item_t             item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output hbrv_result_t           result
);

	logic [THRESH_BITS-1:0] threshold_q;
	logic                   advance;

	hbrv_div_t  div_chain  [DIV_STEPS+1];
	hbrv_sqrt_t sqrt_chain [ROOT_BITS+1];
	hbrv_sqrt_t tail;

	logic [ROOT_BITS-1:0] mag_x;
	logic [ROOT_BITS-1:0] mag_z;
	logic [OUT_BITS-1:0]  ext_x;
	logic [OUT_BITS-1:0]  ext_z;
	hbrv_result_t         packed_res;

	hbrv_result_t result_q;
	logic         result_valid_q;
	hbrv_result_t skid_q;
	logic         skid_valid_q;
	logic         take;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// whole pipe moves unless the skid entry is occupied
	assign advance    = !skid_valid_q;
	assign item_stall = skid_valid_q;

	hbrv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.item_valid (item_valid),
		.item       (item),
		.threshold  (threshold_q),
		.head       (div_chain[0])
	);

	// divider row, one quotient bit per cell
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		hbrv_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.din    (div_chain[i]),
			.dout   (div_chain[i+1])
		);
	end

	// hand the quotients to the square root row
	always_comb begin
		sqrt_chain[0].side   = div_chain[DIV_STEPS].side;
		sqrt_chain[0].rad_x  = RAD_BITS'(div_chain[DIV_STEPS].quo_x);
		sqrt_chain[0].rad_z  = RAD_BITS'(div_chain[DIV_STEPS].quo_z);
		sqrt_chain[0].rem_x  = '0;
		sqrt_chain[0].rem_z  = '0;
		sqrt_chain[0].root_x = '0;
		sqrt_chain[0].root_z = '0;
	end

	// square root row, one root bit per cell
	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
		hbrv_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.din    (sqrt_chain[j]),
			.dout   (sqrt_chain[j+1])
		);
	end

	assign tail = sqrt_chain[ROOT_BITS];

	// saturate to one, apply signs, substitute the fallback vector
	assign mag_x = (tail.root_x > ROOT_ONE) ? ROOT_ONE : tail.root_x;
	assign mag_z = (tail.root_z > ROOT_ONE) ? ROOT_ONE : tail.root_z;
	assign ext_x = OUT_BITS'(mag_x);
	assign ext_z = OUT_BITS'(mag_z);

	always_comb begin
		if (tail.side.degen) begin
			packed_res.right_x    = OUT_ONE;
			packed_res.right_z    = '0;
			packed_res.degenerate = 1'b1;
		end else begin
			packed_res.right_x    = $signed(tail.side.neg_x ? (OUT_BITS'(0) - ext_x) : ext_x);
			packed_res.right_z    = $signed(tail.side.neg_z ? (OUT_BITS'(0) - ext_z) : ext_z);
			packed_res.degenerate = 1'b0;
		end
	end

	// output register and skid entry
	assign take = result_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (tail.side.valid) begin
			if (!result_valid_q || take) begin
				result_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				result_q <= skid_q;
			end
		end else if (tail.side.valid) begin
			if (!result_valid_q || take) begin
				result_q <= packed_res;
			end else begin
				skid_q <= packed_res;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// the skid entry fills only behind a held result
	a_skid_behind_result: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> result_valid_q)
		else $error("skid entry occupied with empty output register");

	// a drained skid entry becomes the next result
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && take) |=> (result_valid_q && result_q == $past(skid_q)))
		else $error("skid entry not moved to output register");

	// fallback results carry the unit x vector
	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.degenerate) |->
		(result_q.right_x == OUT_ONE && result_q.right_z == '0))
		else $error("degenerate result is not (1, 0)");

	// normalized components stay within plus or minus one
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.degenerate) |->
		(result_q.right_x <= OUT_ONE && result_q.right_x >= OUT_NEG_ONE &&
		 result_q.right_z <= OUT_ONE && result_q.right_z >= OUT_NEG_ONE))
		else $error("right vector component out of range");

endmodule

// ===== rtl/core/hbrv_front.sv =====
module hbrv_front
	import hbrv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   item_valid,
	input  hbrv_item_t             item,
	input  logic [THRESH_BITS-1:0] threshold,
	output hbrv_div_t              head
);

	logic                        valid_s1;
	logic signed [DIFF_BITS-1:0] dx_s1;
	logic signed [DIFF_BITS-1:0] dz_s1;

	logic                valid_s2;
	logic [MAG_BITS-1:0] ax_s2;
	logic [MAG_BITS-1:0] az_s2;
	logic                neg_x_s2;
	logic                neg_z_s2;

	logic               valid_s3;
	logic [SQ_BITS-1:0] sqx_s3;
	logic [SQ_BITS-1:0] sqz_s3;
	logic               ax_zero_s3;
	logic               az_zero_s3;
	logic               neg_x_s3;
	logic               neg_z_s3;

	logic      valid_s4;
	hbrv_div_t len_s4;

	logic [DIFF_BITS-1:0] abs_dx;
	logic [DIFF_BITS-1:0] abs_dz;
	logic [LEN_BITS-1:0]  len2;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// s1: camera minus sprite
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DIFF_BITS'(item.camera_x) - DIFF_BITS'(item.sprite_x);
			dz_s1 <= DIFF_BITS'(item.camera_z) - DIFF_BITS'(item.sprite_z);
		end
	end

	// s2: magnitudes and output signs
	assign abs_dx = dx_s1[DIFF_BITS-1] ? DIFF_BITS'(-dx_s1) : DIFF_BITS'(dx_s1);
	assign abs_dz = dz_s1[DIFF_BITS-1] ? DIFF_BITS'(-dz_s1) : DIFF_BITS'(dz_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2    <= abs_dx[MAG_BITS-1:0];
			az_s2    <= abs_dz[MAG_BITS-1:0];
			neg_x_s2 <= dz_s1[DIFF_BITS-1];
			neg_z_s2 <= !dx_s1[DIFF_BITS-1] && (dx_s1 != '0);
		end
	end

	// s3: squares
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3     <= az_s2 * az_s2;
			sqz_s3     <= ax_s2 * ax_s2;
			ax_zero_s3 <= (ax_s2 == '0);
			az_zero_s3 <= (az_s2 == '0);
			neg_x_s3   <= neg_x_s2;
			neg_z_s3   <= neg_z_s2;
		end
	end

	// s4: squared length, threshold test, top quotient bit.
	// a^2 >= L only when the other component is zero, and then a^2 == L.
	assign len2 = LEN_BITS'(sqx_s3) + LEN_BITS'(sqz_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			len_s4.side.valid <= valid_s3;
			len_s4.side.neg_x <= neg_x_s3;
			len_s4.side.neg_z <= neg_z_s3;
			len_s4.side.degen <= (len2 == '0) || (THRESH_BITS'(len2) < threshold);
			len_s4.divisor    <= len2;
			len_s4.rem_x      <= ax_zero_s3 ? '0 : LEN_BITS'(sqx_s3);
			len_s4.rem_z      <= az_zero_s3 ? '0 : LEN_BITS'(sqz_s3);
			len_s4.quo_x      <= QUO_BITS'(ax_zero_s3);
			len_s4.quo_z      <= QUO_BITS'(az_zero_s3);
		end
	end

	always_comb begin
		head            = len_s4;
		head.side.valid = valid_s4;
	end

endmodule

// ===== rtl/core/hbrv_div_cell.sv =====
module hbrv_div_cell
	import hbrv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  hbrv_div_t din,
	output hbrv_div_t dout
);

	logic      valid_q;
	hbrv_div_t data_q;

	logic [LEN_BITS:0] shift_x;
	logic [LEN_BITS:0] shift_z;
	logic [LEN_BITS:0] diff_x;
	logic [LEN_BITS:0] diff_z;
	logic              ge_x;
	logic              ge_z;

	// one restoring step per lane: doubled remainder minus divisor
	assign shift_x = {din.rem_x, 1'b0};
	assign shift_z = {din.rem_z, 1'b0};
	assign diff_x  = shift_x - {1'b0, din.divisor};
	assign diff_z  = shift_z - {1'b0, din.divisor};
	assign ge_x    = !diff_x[LEN_BITS];
	assign ge_z    = !diff_z[LEN_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= din.side.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q.side    <= din.side;
			data_q.divisor <= din.divisor;
			data_q.rem_x   <= ge_x ? diff_x[LEN_BITS-1:0] : shift_x[LEN_BITS-1:0];
			data_q.rem_z   <= ge_z ? diff_z[LEN_BITS-1:0] : shift_z[LEN_BITS-1:0];
			data_q.quo_x   <= {din.quo_x[QUO_BITS-2:0], ge_x};
			data_q.quo_z   <= {din.quo_z[QUO_BITS-2:0], ge_z};
		end
	end

	always_comb begin
		dout            = data_q;
		dout.side.valid = valid_q;
	end

endmodule

// ===== rtl/core/hbrv_sqrt_cell.sv =====
module hbrv_sqrt_cell
	import hbrv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  hbrv_sqrt_t din,
	output hbrv_sqrt_t dout
);

	localparam int TW = SREM_BITS + 2;

	logic       valid_q;
	hbrv_sqrt_t data_q;

	logic [TW-1:0] acc_x;
	logic [TW-1:0] acc_z;
	logic [TW-1:0] trial_x;
	logic [TW-1:0] trial_z;
	logic [TW-1:0] diff_x;
	logic [TW-1:0] diff_z;
	logic          ge_x;
	logic          ge_z;

	// bring down the next bit pair, try root*4+1
	assign acc_x   = {din.rem_x, din.rad_x[RAD_BITS-1 -: 2]};
	assign acc_z   = {din.rem_z, din.rad_z[RAD_BITS-1 -: 2]};
	assign trial_x = TW'({din.root_x, 2'b01});
	assign trial_z = TW'({din.root_z, 2'b01});
	assign ge_x    = (acc_x >= trial_x);
	assign ge_z    = (acc_z >= trial_z);
	assign diff_x  = acc_x - trial_x;
	assign diff_z  = acc_z - trial_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= din.side.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q.side   <= din.side;
			data_q.rad_x  <= {din.rad_x[RAD_BITS-3:0], 2'b00};
			data_q.rad_z  <= {din.rad_z[RAD_BITS-3:0], 2'b00};
			data_q.rem_x  <= ge_x ? diff_x[SREM_BITS-1:0] : acc_x[SREM_BITS-1:0];
			data_q.rem_z  <= ge_z ? diff_z[SREM_BITS-1:0] : acc_z[SREM_BITS-1:0];
			data_q.root_x <= {din.root_x[ROOT_BITS-2:0], ge_x};
			data_q.root_z <= {din.root_z[ROOT_BITS-2:0], ge_z};
		end
	end

	always_comb begin
		dout            = data_q;
		dout.side.valid = valid_q;
	end

endmodule

// ===== dv/right_vector_checker.sv =====
`timescale 1ns / 100ps

module right_vector_checker
	import hbrv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [THRESH_BITS-1:0] cfg_wdata,
	input  logic                   item_valid,
	input  logic                   item_stall,
	input  hbrv_item_t             item,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  hbrv_result_t           result,
	output int                     pending,
	output int                     mismatch_count,
	output int                     fallback_count
);

	// Threshold as the block should hold it
	logic [THRESH_BITS-1:0] threshold;
	hbrv_result_t           expected_vectors[$];
	hbrv_result_t           want;
	int                     errors;

	assign mismatch_count = errors;

	// floor(sqrt(a^2 * 2^(2F) / len2)), clamped to one
	function automatic logic [ROOT_BITS-1:0] unit_magnitude(input longint unsigned a,
			input longint unsigned len2);
		logic [79:0]          quo;
		logic [ROOT_BITS-1:0] root;
		logic [ROOT_BITS-1:0] trial;
		quo  = ((80'(a) * 80'(a)) << (2 * OUT_FRAC_BITS)) / 80'(len2);
		root = '0;
		for (int b = ROOT_BITS - 1; b >= 0; b--) begin
			trial = root | (ROOT_BITS'(1) << b);
			if (80'(trial) * 80'(trial) <= quo)
				root = trial;
		end
		if (root > ROOT_ONE)
			root = ROOT_ONE;
		return root;
	endfunction

	// Right vector (dz, -dx) / |d|, or the fallback (1, 0)
	function automatic hbrv_result_t predict_right_vector(input hbrv_item_t it,
			input logic [THRESH_BITS-1:0] thr);
		hbrv_result_t               r;
		longint                     dx;
		longint                     dz;
		longint unsigned            ax;
		longint unsigned            az;
		longint unsigned            len2;
		logic signed [OUT_BITS-1:0] mx;
		logic signed [OUT_BITS-1:0] mz;
		dx   = longint'(it.camera_x) - longint'(it.sprite_x);
		dz   = longint'(it.camera_z) - longint'(it.sprite_z);
		ax   = (dx < 0) ? -dx : dx;
		az   = (dz < 0) ? -dz : dz;
		len2 = ax * ax + az * az;
		// zero length can never be normalized, whatever the threshold
		if (len2 == 0 || len2 < 64'(thr)) begin
			r.right_x    = OUT_ONE;
			r.right_z    = '0;
			r.degenerate = 1'b1;
		end else begin
			mx           = OUT_BITS'(unit_magnitude(az, len2));
			mz           = OUT_BITS'(unit_magnitude(ax, len2));
			r.right_x    = (dz < 0) ? -mx : mx;
			r.right_z    = (dx > 0) ? -mz : mz;
			r.degenerate = 1'b0;
		end
		return r;
	endfunction

	// Watch both channels and the config port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = THRESH_RESET;
			expected_vectors.delete();
			errors         = 0;
			pending        <= 0;
			fallback_count <= 0;
		end else begin
			if (item_valid && !item_stall)
				expected_vectors.push_back(predict_right_vector(item, threshold));
			if (cfg_we)
				threshold = cfg_wdata;
			if (result_valid && !result_stall) begin
				if (result.degenerate === 1'b1)
					fallback_count <= fallback_count + 1;
				if (expected_vectors.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: result beat x=%0d z=%0d deg=%0b with nothing expected",
							result.right_x, result.right_z, result.degenerate);
				end else begin
					want = expected_vectors.pop_front();
					if (result.right_x !== want.right_x || result.right_z !== want.right_z ||
							result.degenerate !== want.degenerate) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected x=%0d z=%0d deg=%0b, got x=%0d z=%0d deg=%0b",
								want.right_x, want.right_z, want.degenerate,
								result.right_x, result.right_z, result.degenerate);
					end
				end
			end
			pending <= expected_vectors.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
	import hbrv_pkg::*;
();

	localparam int PIPE_LATENCY = 48;
	localparam int STALL_LIMIT  = 2000;
	localparam int CMAX         = 2 ** (COORD_BITS - 1) - 1;
	localparam int CMIN         = -(2 ** (COORD_BITS - 1));

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_we       = 1'b0;
	logic [THRESH_BITS-1:0] cfg_wdata    = '0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	hbrv_item_t             item         = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	hbrv_result_t           result;

	int pending;
	int mismatch_count;
	int fallback_count;
	int beats_sent     = 0;
	int settings_used  = 0;
	int idle_cycles    = 0;
	bit quiet          = 1'b0;

	always #2 clk = ~clk;

	horizontal_billboard_right_vector_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	right_vector_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.pending       (pending),
		.mismatch_count(mismatch_count),
		.fallback_count(fallback_count)
	);

	function automatic hbrv_item_t coords(input int sx, input int sz, input int cx, input int cz);
		hbrv_item_t it;
		it.sprite_x = COORD_BITS'(sx);
		it.sprite_z = COORD_BITS'(sz);
		it.camera_x = COORD_BITS'(cx);
		it.camera_z = COORD_BITS'(cz);
		return it;
	endfunction

	// Signed offset of up to k+1 bits
	function automatic logic [COORD_BITS-1:0] near_offset(input int k);
		logic [COORD_BITS-1:0] m;
		m = COORD_BITS'($urandom) >> (COORD_BITS - 1 - k);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic logic [COORD_BITS-1:0] corner_coord();
		case ($urandom_range(0, 4))
			0:       return COORD_BITS'(CMIN);
			1:       return COORD_BITS'(CMAX);
			2:       return '0;
			3:       return '1;
			default: return COORD_BITS'(1);
		endcase
	endfunction

	// Mostly nearby sprite/camera pairs, plus wide, corner, axis and coincident cases
	function automatic hbrv_item_t random_beat();
		hbrv_item_t it;
		int         kind;
		int         k;
		it   = hbrv_item_t'({$urandom, $urandom, $urandom});
		kind = $urandom_range(0, 9);
		k    = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : $urandom_range(0, 23);
		if (kind >= 3 && kind <= 8) begin
			it.camera_x = it.sprite_x + near_offset(k);
			it.camera_z = it.sprite_z + near_offset(k);
			if (kind == 8) begin
				if ($urandom_range(0, 1))
					it.camera_x = it.sprite_x;
				else
					it.camera_z = it.sprite_z;
			end
		end else if (kind == 7) begin
			it = {corner_coord(), corner_coord(), corner_coord(), corner_coord()};
		end else if (kind == 9) begin
			it.camera_x = it.sprite_x;
			it.camera_z = it.sprite_z;
		end
		if (kind == 7)
			it = {corner_coord(), corner_coord(), corner_coord(), corner_coord()};
		return it;
	endfunction

	function automatic logic [THRESH_BITS-1:0] random_threshold();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			2:       return THRESH_BITS'($urandom_range(0, 4096));
			3:       return THRESH_BITS'(1) << $urandom_range(0, THRESH_BITS - 1);
			default: return THRESH_BITS'({$urandom, $urandom}) >> $urandom_range(0, 40);
		endcase
	endfunction

	// Present one beat, hold it until taken, then maybe pause
	task automatic send_beat(input hbrv_item_t it);
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		beats_sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Drain the pipe, then write the threshold
	task automatic set_threshold(input logic [THRESH_BITS-1:0] value);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Result side back-pressure in bursts
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog: no beat moving on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold: extremes, each axis direction, both sides of the threshold
		send_beat(coords(0, 0, 0, 0));
		send_beat(coords(CMIN, CMIN, CMAX, CMAX));
		send_beat(coords(CMAX, CMAX, CMIN, CMIN));
		send_beat(coords(CMAX, CMIN, CMIN, CMAX));
		send_beat(coords(0, 0, 4096, 0));
		send_beat(coords(0, 0, -4096, 0));
		send_beat(coords(0, 0, 0, 4096));
		send_beat(coords(0, 0, 0, -4096));
		send_beat(coords(100, -200, 100, -160));
		send_beat(coords(100, -200, 100, -159));
		send_beat(coords(-1, -1, 0, 0));
		send_beat(coords(5000, -7000, -12345, 23456));
		send_beat(coords(-1, 1, 1000, -3));

		// zero threshold: coincident points still fall back
		set_threshold('0);
		send_beat(coords(77, -77, 77, -77));
		send_beat(coords(0, 0, 1, 0));
		send_beat(coords(0, 0, -1, -1));

		// all-ones threshold: everything falls back
		set_threshold('1);
		send_beat(coords(CMIN, CMAX, CMAX, CMIN));
		send_beat(coords(0, 0, 3, 4));

		// length equal to the threshold is not below it
		set_threshold(THRESH_BITS'(1681));
		send_beat(coords(0, 0, 0, 41));
		send_beat(coords(0, 0, 40, 0));
		send_beat(coords(0, 0, 9, -40));

		// random phases, the last two without any idling
		for (int ph = 0; ph < 6; ph++) begin
			set_threshold(random_threshold());
			quiet = (ph >= 4);
			repeat (150) send_beat(random_beat());
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 8) @(posedge clk);

		$display("run covered %0d input beats under %0d threshold settings",
			beats_sent, settings_used + 1);
		$display("%0d results took the fallback vector, %0d mismatches",
			fallback_count, mismatch_count);
		if (mismatch_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== horizontal_billboard_right_vector_unit.f =====
rtl/core/hbrv_pkg.sv
rtl/core/hbrv_front.sv
rtl/core/hbrv_div_cell.sv
rtl/core/hbrv_sqrt_cell.sv
rtl/core/horizontal_billboard_right_vector_unit.sv
dv/right_vector_checker.sv
dv/tb_top.sv
